/* sv/iyfu_pkg.sv */
// Shared types and constants for the yaw frame unwrapper.
`default_nettype none
package iyfu_pkg;

  localparam int unsigned RegIdxW = 3;
  localparam int unsigned AddrW   = 5;

  localparam logic [RegIdxW-1:0] REG_SYNC_BYTE      = 3'd0;
  localparam logic [RegIdxW-1:0] REG_TYPE_BYTE      = 3'd1;
  localparam logic [RegIdxW-1:0] REG_FRAME_LENGTH   = 3'd2;
  localparam logic [RegIdxW-1:0] REG_YAW_INDEX      = 3'd3;
  localparam logic [RegIdxW-1:0] REG_WRAP_THRESHOLD = 3'd4;

  localparam logic [7:0]  SYNC_BYTE_RST      = 8'd85;
  localparam logic [7:0]  TYPE_BYTE_RST      = 8'd83;
  localparam logic [5:0]  FRAME_LENGTH_RST   = 6'd33;
  localparam logic [5:0]  YAW_INDEX_RST      = 6'd5;
  localparam logic [15:0] WRAP_THRESHOLD_RST = 16'd45511;

  localparam logic [1:0] STATUS_ANGLE = 2'd0;
  localparam logic [1:0] STATUS_HUNT  = 2'd1;
  localparam logic [1:0] STATUS_ZERO  = 2'd2;

  typedef struct packed {
    logic [7:0]  sync_byte;
    logic [7:0]  type_byte;
    logic [5:0]  frame_length;
    logic [5:0]  yaw_index;
    logic [15:0] wrap_threshold;
  } iyfu_cfg_t;

  typedef struct packed {
    logic        func;
    logic [7:0]  data_byte;
  } iyfu_item_t;

  typedef struct packed {
    logic signed [32:0] heading;
    logic [15:0]        raw_yaw;
    logic [1:0]         status;
  } iyfu_result_t;

endpackage
`default_nettype wire

/* sv/iyfu_core.sv */
// Framing, yaw capture and unwrap state with its combinational update logic.
`default_nettype none
module iyfu_core (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire iyfu_pkg::iyfu_cfg_t   cfg,
  input  wire iyfu_pkg::iyfu_item_t  item,
  input  wire logic                  item_valid,
  input  wire logic                  step,
  output logic                       res_valid,
  output iyfu_pkg::iyfu_result_t     res
);
  import iyfu_pkg::*;

  logic               hunting, hunting_next;
  logic [5:0]         byte_count, byte_count_next;
  logic [7:0]         first_byte, first_byte_next;
  logic [7:0]         yaw_low, yaw_low_next;
  logic [7:0]         yaw_high, yaw_high_next;
  logic [15:0]        current_yaw, current_yaw_next;
  logic signed [15:0] turn_count, turn_count_next;

  logic [6:0]         pos_inc;
  logic [15:0]        new_yaw;
  logic signed [16:0] diff;
  logic signed [16:0] thr;

  always_comb begin
    hunting_next     = hunting;
    byte_count_next  = byte_count;
    first_byte_next  = first_byte;
    yaw_low_next     = yaw_low;
    yaw_high_next    = yaw_high;
    current_yaw_next = current_yaw;
    turn_count_next  = turn_count;
    res_valid        = 1'b0;
    res.status       = STATUS_ANGLE;
    pos_inc          = {1'b0, byte_count} + 7'd1;
    new_yaw          = 16'd0;
    diff             = 17'sd0;
    thr              = $signed({1'b0, cfg.wrap_threshold});

    if (item.func) begin
      hunting_next     = 1'b0;
      byte_count_next  = 6'd0;
      first_byte_next  = 8'd0;
      yaw_low_next     = 8'd0;
      yaw_high_next    = 8'd0;
      current_yaw_next = 16'd0;
      turn_count_next  = 16'sd0;
      res_valid        = item_valid;
      res.status       = STATUS_ZERO;
    end else if (hunting) begin
      if (item.data_byte == cfg.sync_byte) begin
        hunting_next    = 1'b0;
        byte_count_next = 6'd0;
      end
    end else begin
      if (byte_count == 6'd0) first_byte_next = item.data_byte;
      if (byte_count == cfg.yaw_index) yaw_low_next = item.data_byte;
      // The high byte sits one past the index; index 63 never reaches it.
      if ({1'b0, byte_count} == {1'b0, cfg.yaw_index} + 7'd1) begin
        yaw_high_next = item.data_byte;
      end
      if (pos_inc < {1'b0, cfg.frame_length}) begin
        byte_count_next = pos_inc[5:0];
      end else begin
        byte_count_next = 6'd0;
        res_valid       = item_valid;
        if (first_byte_next != cfg.type_byte) begin
          hunting_next = 1'b1;
          res.status   = STATUS_HUNT;
        end else begin
          new_yaw          = {yaw_high_next, yaw_low_next};
          current_yaw_next = new_yaw;
          diff             = $signed({1'b0, new_yaw}) - $signed({1'b0, current_yaw});
          if (diff > thr) begin
            if (turn_count != 16'sh7fff) turn_count_next = turn_count + 16'sd1;
          end else if (diff < -thr) begin
            if (turn_count != -16'sh8000) turn_count_next = turn_count - 16'sd1;
          end
        end
      end
    end

    res.raw_yaw = current_yaw_next;
    res.heading = $signed({17'd0, current_yaw_next})
                - $signed({turn_count_next[15], turn_count_next, 16'd0});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hunting     <= 1'b0;
      byte_count  <= 6'd0;
      first_byte  <= 8'd0;
      yaw_low     <= 8'd0;
      yaw_high    <= 8'd0;
      current_yaw <= 16'd0;
      turn_count  <= 16'sd0;
    end else if (step) begin
      hunting     <= hunting_next;
      byte_count  <= byte_count_next;
      first_byte  <= first_byte_next;
      yaw_low     <= yaw_low_next;
      yaw_high    <= yaw_high_next;
      current_yaw <= current_yaw_next;
      turn_count  <= turn_count_next;
    end
  end

endmodule
`default_nettype wire

/* sv/iyfu_skid.sv */
// Two-entry result buffer between the update logic and the output channel.
`default_nettype none
module iyfu_skid (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    push,
  input  wire iyfu_pkg::iyfu_result_t  push_data,
  output logic                         room,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output iyfu_pkg::iyfu_result_t       out_data
);
  import iyfu_pkg::*;

  iyfu_result_t entry [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         pop;

  assign out_valid = (count != 2'd0);
  assign room      = (count != 2'd2);
  assign pop       = out_valid && !out_stall;
  assign out_data  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_data;
  end

endmodule
`default_nettype wire

/* sv/imu_yaw_frame_unwrap.sv */
// Top level of the yaw frame unwrapper: register port, input register and wiring.
//
// Input channel: one beat is one link byte (func 0) or a zero command (func 1),
// accepted when in_valid is high and in_stall low. Output channel: one beat per
// finished frame (status 0 angle updated, status 1 bad type and now hunting for
// the sync byte) or per zero command (status 2), taken when out_valid is high and
// out_stall low. Bytes that do not finish a frame give no beat.
// Each beat is held in the input register while the update logic works on it,
// and its result enters the buffer at the edge where the beat moves on. A result
// is on the output once it is in the buffer and is taken while out_stall is low.
// A new beat can be accepted every cycle while in_stall is low; throughput is one byte per clock.
// A two-entry result buffer takes two more results while the receiver stalls;
// once it is full, in_stall rises whenever the held beat would make a result and
// stays high until a result is taken.
// Reset clears framing, captured bytes, the yaw and the turn count, empties the
// buffer and returns the registers to their defaults. Registers are written over
// the APB port at byte addresses 0, 4, 8, 12 and 16 and should be changed only
// while no beat is in flight.
`default_nettype none
module imu_yaw_frame_unwrap (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [iyfu_pkg::AddrW-1:0] paddr,
  input  wire logic [31:0]              pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic                     func,
  input  wire logic [7:0]               data_byte,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [32:0]            heading,
  output logic [15:0]                   raw_yaw,
  output logic [1:0]                    status
);
  import iyfu_pkg::*;

  iyfu_cfg_t             cfg;
  logic [RegIdxW-1:0]    reg_idx;
  logic                  wr_en;

  iyfu_item_t            item;
  logic                  item_valid;
  logic                  res_valid;
  iyfu_result_t          res;
  logic                  room;
  logic                  step;
  iyfu_result_t          out_data;

  assign pready  = 1'b1;
  assign reg_idx = paddr[AddrW-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_byte      <= SYNC_BYTE_RST;
      cfg.type_byte      <= TYPE_BYTE_RST;
      cfg.frame_length   <= FRAME_LENGTH_RST;
      cfg.yaw_index      <= YAW_INDEX_RST;
      cfg.wrap_threshold <= WRAP_THRESHOLD_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SYNC_BYTE:      cfg.sync_byte      <= pwdata[7:0];
        REG_TYPE_BYTE:      cfg.type_byte      <= pwdata[7:0];
        REG_FRAME_LENGTH:   cfg.frame_length   <= pwdata[5:0];
        REG_YAW_INDEX:      cfg.yaw_index      <= pwdata[5:0];
        REG_WRAP_THRESHOLD: cfg.wrap_threshold <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SYNC_BYTE:      prdata = {24'd0, cfg.sync_byte};
      REG_TYPE_BYTE:      prdata = {24'd0, cfg.type_byte};
      REG_FRAME_LENGTH:   prdata = {26'd0, cfg.frame_length};
      REG_YAW_INDEX:      prdata = {26'd0, cfg.yaw_index};
      REG_WRAP_THRESHOLD: prdata = {16'd0, cfg.wrap_threshold};
      default:            prdata = 32'd0;
    endcase
  end

  // The held beat moves on unless it makes a result and the buffer is full.
  assign step     = item_valid && (!res_valid || room);
  assign in_stall = item_valid && !step;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item.func      <= func;
      item.data_byte <= data_byte;
    end
  end

  iyfu_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item       (item),
    .item_valid (item_valid),
    .step       (step),
    .res_valid  (res_valid),
    .res        (res)
  );

  iyfu_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (step && res_valid),
    .push_data (res),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign heading = out_data.heading;
  assign raw_yaw = out_data.raw_yaw;
  assign status  = out_data.status;

endmodule
`default_nettype wire
